>>> hw/rtl/prts_pkg.sv
package prts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int PRIO_W    = 8;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [PRIO_W-1:0] t_prio;

    localparam logic MODE_CREATE = 1'b0;
    localparam logic MODE_SCHED  = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_ALIGN,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        CH_HOLD,
        CH_ROTATE,
        CH_INSERT
    } t_chain_op;

    typedef struct packed {
        t_idx  slot;
        t_prio prio;
    } t_entry;

    typedef struct packed {
        t_chain_op op;
        t_cnt      count;
        t_entry    new_entry;
    } t_chain_ctl;

    function automatic logic slot_ready(logic [15:0] mask, t_idx slot);
        logic r;
        r = 1'b0;
        for (int j = 0; j < 16; j++) begin
            if (int'(slot) == j) begin
                r = mask[j];
            end
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/priority_round_robin_task_scheduler_top.sv
// Priority round-robin task scheduler.
// Input channel: i_in_valid / o_in_stall with i_mode, i_new_priority and
// i_ready_mask; a transfer happens on an edge with i_in_valid high and
// o_in_stall low. Output channel: o_out_valid / i_out_stall with o_status
// and o_task_index; exactly one result per input transfer, in order.
// Tasks sit in a chain of cells kept in ring order with the current task
// in cell 0. A create inserts the new slot into cell 1. A schedule
// rotates the chain once through all N tasks in use, checking cell 0
// each cycle, then rotates on by the offset R of the chosen task so it
// lands in cell 0. One item is in work at a time; o_in_stall is high from
// the transfer until the result is loaded into the output register, and the
// next transfer can follow in the cycle after that.
// Reset (synchronous, active low) leaves only the idle task in slot 0 with
// priority 0 as the current task, and no result pending. While i_out_stall
// holds a result, the next result waits in the block and the input stays
// stalled once that item is finished.
module priority_round_robin_task_scheduler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_new_priority,
    input  logic [15:0] i_ready_mask,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_status,
    output logic [3:0]  o_task_index
);

    prts_pkg::t_chain_ctl w_ctl;
    prts_pkg::t_entry     w_cell [prts_pkg::MAX_TASKS];

    prts_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_new_priority (i_new_priority),
        .i_ready_mask   (i_ready_mask),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_task_index   (o_task_index),
        .i_head         (w_cell[0]),
        .o_ctl          (w_ctl)
    );

    for (genvar i = 0; i < prts_pkg::MAX_TASKS; i++) begin : g_cell
        prts_pkg::t_entry w_left;
        prts_pkg::t_entry w_right;

        if (i == 0) begin : g_first
            assign w_left = w_cell[i];
        end else begin : g_mid_l
            assign w_left = w_cell[i-1];
        end

        if (i == prts_pkg::MAX_TASKS - 1) begin : g_end
            assign w_right = w_cell[i];
        end else begin : g_mid_r
            assign w_right = w_cell[i+1];
        end

        prts_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pos   (prts_pkg::t_idx'(i)),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_cell[0]),
            .o_entry (w_cell[i])
        );
    end

endmodule

>>> hw/rtl/prts_cell.sv
module prts_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  prts_pkg::t_idx      i_pos,
    input  prts_pkg::t_chain_ctl i_ctl,
    input  prts_pkg::t_entry    i_left,
    input  prts_pkg::t_entry    i_right,
    input  prts_pkg::t_entry    i_head,
    output prts_pkg::t_entry    o_entry
);

    prts_pkg::t_entry r_entry;
    prts_pkg::t_entry n_entry;
    logic             w_last;

    assign w_last = (prts_pkg::t_cnt'(i_pos) == (i_ctl.count - 1'b1));

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctl.op)
            prts_pkg::CH_HOLD: begin
                n_entry = r_entry;
            end
            prts_pkg::CH_ROTATE: begin
                n_entry = w_last ? i_head : i_right;
            end
            prts_pkg::CH_INSERT: begin
                if (i_pos == prts_pkg::t_idx'(1)) begin
                    n_entry = i_ctl.new_entry;
                end else if (i_pos > prts_pkg::t_idx'(1)) begin
                    n_entry = i_left;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

>>> hw/rtl/prts_seq.sv
module prts_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_mode,
    input  logic [7:0]           i_new_priority,
    input  logic [15:0]          i_ready_mask,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_status,
    output logic [3:0]           o_task_index,
    input  prts_pkg::t_entry     i_head,
    output prts_pkg::t_chain_ctl o_ctl
);

    prts_pkg::t_state r_state;
    prts_pkg::t_state n_state;
    prts_pkg::t_cnt   r_count;
    prts_pkg::t_idx   r_step;
    logic [15:0]      r_mask;
    prts_pkg::t_prio  r_best_prio;
    prts_pkg::t_prio  r_cur_prio;
    prts_pkg::t_idx   r_best_off;
    prts_pkg::t_idx   r_eq_off;
    prts_pkg::t_idx   r_idle_off;
    logic             r_found;
    logic             r_eq_found;
    prts_pkg::t_idx   r_rot;
    logic             r_res_status;
    logic [3:0]       r_res_idx;
    logic             r_out_valid;
    logic             r_out_status;
    logic [3:0]       r_out_idx;

    logic             w_accept;
    logic             w_full;
    logic             w_out_free;
    logic             w_last_step;
    logic             w_rdy;
    prts_pkg::t_prio  w_cur_prio;
    prts_pkg::t_idx   w_pick;

    assign w_accept    = i_in_valid && (r_state == prts_pkg::S_IDLE);
    assign w_full      = (r_count == prts_pkg::t_cnt'(prts_pkg::MAX_TASKS));
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_last_step = (prts_pkg::t_cnt'(r_step) == (r_count - 1'b1));
    assign w_rdy       = prts_pkg::slot_ready(r_mask, i_head.slot);
    assign w_cur_prio  = (r_step == '0) ? i_head.prio : r_cur_prio;

    always_comb begin
        w_pick = r_found ? r_best_off : r_idle_off;
        if ((w_pick == '0) && r_eq_found) begin
            w_pick = r_eq_off;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prts_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_mode == prts_pkg::MODE_CREATE) ?
                              prts_pkg::S_FINISH : prts_pkg::S_SCAN;
                end
            end
            prts_pkg::S_SCAN: begin
                if (w_last_step) begin
                    n_state = prts_pkg::S_PICK;
                end
            end
            prts_pkg::S_PICK: begin
                n_state = prts_pkg::S_ALIGN;
            end
            prts_pkg::S_ALIGN: begin
                if (r_rot == '0) begin
                    n_state = prts_pkg::S_FINISH;
                end
            end
            prts_pkg::S_FINISH: begin
                if (w_out_free) begin
                    n_state = prts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = prts_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctl.op             = prts_pkg::CH_HOLD;
        o_ctl.count          = r_count;
        o_ctl.new_entry.slot = prts_pkg::t_idx'(r_count);
        o_ctl.new_entry.prio = prts_pkg::t_prio'(i_new_priority);
        unique case (r_state)
            prts_pkg::S_IDLE: begin
                if (w_accept && (i_mode == prts_pkg::MODE_CREATE) && !w_full) begin
                    o_ctl.op = prts_pkg::CH_INSERT;
                end
            end
            prts_pkg::S_SCAN: begin
                o_ctl.op = prts_pkg::CH_ROTATE;
            end
            prts_pkg::S_ALIGN: begin
                if (r_rot != '0) begin
                    o_ctl.op = prts_pkg::CH_ROTATE;
                end
            end
            default: begin
                o_ctl.op = prts_pkg::CH_HOLD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= prts_pkg::S_IDLE;
            r_count     <= prts_pkg::t_cnt'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && (i_mode == prts_pkg::MODE_CREATE) && !w_full) begin
                r_count <= r_count + 1'b1;
            end
            if ((r_state == prts_pkg::S_FINISH) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            prts_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_mask      <= i_ready_mask;
                    r_best_prio <= '0;
                    r_found     <= 1'b0;
                    r_eq_found  <= 1'b0;
                    r_step      <= '0;
                    r_best_off  <= '0;
                    r_eq_off    <= '0;
                    r_idle_off  <= '0;
                    r_res_status <= w_full ? prts_pkg::ST_FULL : prts_pkg::ST_OK;
                    r_res_idx    <= w_full ? 4'd0 : 4'(r_count);
                end
            end
            prts_pkg::S_SCAN: begin
                r_step <= r_step + 1'b1;
                if (r_step == '0) begin
                    r_cur_prio <= i_head.prio;
                end
                if (w_rdy && (i_head.prio > r_best_prio)) begin
                    r_best_prio <= i_head.prio;
                    r_best_off  <= r_step;
                    r_found     <= 1'b1;
                end
                if ((r_step != '0) && w_rdy && !r_eq_found && (i_head.prio == w_cur_prio)) begin
                    r_eq_found <= 1'b1;
                    r_eq_off   <= r_step;
                end
                if (i_head.slot == '0) begin
                    r_idle_off <= r_step;
                end
            end
            prts_pkg::S_PICK: begin
                r_rot <= w_pick;
            end
            prts_pkg::S_ALIGN: begin
                if (r_rot != '0) begin
                    r_rot <= r_rot - 1'b1;
                end else begin
                    r_res_status <= prts_pkg::ST_OK;
                    r_res_idx    <= 4'(i_head.slot);
                end
            end
            prts_pkg::S_FINISH: begin
                if (w_out_free) begin
                    r_out_status <= r_res_status;
                    r_out_idx    <= r_res_idx;
                end
            end
            default: begin
                r_rot <= r_rot;
            end
        endcase
    end

    assign o_in_stall   = (r_state != prts_pkg::S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_task_index = r_out_idx;

endmodule

>>> hw/rtl/prts_chk.sv
module prts_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_mode,
    input logic [7:0]  i_new_priority,
    input logic [15:0] i_ready_mask,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_status,
    input logic [3:0]  o_task_index
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled while item in work");

    a_full_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == 1'b1)) |-> (o_task_index == 4'd0))
        else $error("table-full result with non-zero index");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_task_index)))
        else $error("stalled result changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=>
            (i_in_valid && $stable(i_mode) && $stable(i_new_priority) &&
             $stable(i_ready_mask)))
        else $error("stalled input changed");

endmodule

bind priority_round_robin_task_scheduler_top prts_chk u_prts_chk (.*);
